@@ rtl/ple_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Operation and status codes, and the request and result transfer structs.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 32;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_APPEND    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DEL_END   = 3'd6,
    OP_DISPLAY   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_EXISTS = 3'd4,
    ST_NONE   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [15:0]        position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         length;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/ple_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_mem: list entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_mem
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  wire logic [31:0]                 wr_data,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic      [31:0]                 rd_data
);

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ple_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_seq: request sequencer of the positional list engine
// Checks each request, then walks the storage with one index counter to
// shift entries up or down, write a new entry, or stream the list out.
// ----------------------------------------------------------------------------
module ple_seq
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire req_t                        in_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output res_t                             res_data,
  output logic                             mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
  output logic [31:0]                      mem_wr_data,
  output logic                             mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
  input  wire logic [31:0]                 mem_rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_LAST,
    S_PUT,
    S_DN,
    S_DN_LAST,
    S_DISP_RD,
    S_DISP_OUT,
    S_RESULT
  } state_t;

  state_t        state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          pend_r, pend_nxt;
  logic [31:0]   val_r, val_nxt;
  status_t       status_r, status_nxt;

  logic          do_ins, do_del;
  logic [AW-1:0] tgt_idx;
  logic [15:0]   pos_m1;
  logic [16:0]   len_p1;
  logic          pos_bad_ins, pos_bad_del;
  logic          is_last;
  logic [LW-1:0] len_m1;
  logic [LW+5:0] len_ext;

  assign in_ready    = (state_r == S_IDLE);
  assign pos_m1      = in_data.position - 16'd1;
  assign len_p1      = 17'(len_r) + 17'd1;
  assign pos_bad_ins = (in_data.position == 16'd0) || ({1'b0, in_data.position} > len_p1);
  assign pos_bad_del = (in_data.position == 16'd0) || (in_data.position > 16'(len_r));
  assign len_m1      = len_r - LW'(1);
  assign is_last     = (LW'(cnt_r) == len_m1);
  assign len_ext     = {6'd0, len_r};

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    wptr_nxt    = wptr_r;
    pend_nxt    = pend_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    tgt_idx     = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wptr_r;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_r;
    res_valid   = 1'b0;
    res_data.status  = status_r;
    res_data.element = '0;
    res_data.last    = 1'b1;
    res_data.length  = len_ext[5:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_data.value;
          status_nxt = ST_OK;
          state_nxt  = S_RESULT;
          case (in_data.op)
            OP_CREATE: begin
              if (len_r != '0) status_nxt = ST_EXISTS;
              else do_ins = 1'b1;
            end
            OP_INS_FRONT: begin
              if (len_r == '0) status_nxt = ST_NONE;
              else if (len_r >= CAP_L) status_nxt = ST_FULL;
              else do_ins = 1'b1;
            end
            OP_INS_POS: begin
              if (pos_bad_ins) status_nxt = ST_RANGE;
              else if (len_r >= CAP_L) status_nxt = ST_FULL;
              else begin
                do_ins  = 1'b1;
                tgt_idx = pos_m1[AW-1:0];
              end
            end
            OP_APPEND: begin
              if (len_r >= CAP_L) status_nxt = ST_FULL;
              else begin
                do_ins  = 1'b1;
                tgt_idx = AW'(len_r);
              end
            end
            OP_DEL_FRONT: begin
              if (len_r == '0) status_nxt = ST_EMPTY;
              else do_del = 1'b1;
            end
            OP_DEL_POS: begin
              if (len_r == '0) status_nxt = ST_EMPTY;
              else if (pos_bad_del) status_nxt = ST_RANGE;
              else begin
                do_del  = 1'b1;
                tgt_idx = pos_m1[AW-1:0];
              end
            end
            OP_DEL_END: begin
              if (len_r == '0) status_nxt = ST_EMPTY;
              else len_nxt = len_m1;
            end
            default: begin
              if (len_r == '0) status_nxt = ST_EMPTY;
              else begin
                cnt_nxt   = '0;
                state_nxt = S_DISP_RD;
              end
            end
          endcase
          pend_nxt = 1'b0;
          idx_nxt  = tgt_idx;
          if (do_ins) begin
            if (LW'(tgt_idx) == len_r) begin
              state_nxt = S_PUT;
            end else begin
              cnt_nxt   = AW'(len_m1);
              state_nxt = S_UP;
            end
          end
          if (do_del) begin
            if (LW'(tgt_idx) == len_m1) begin
              len_nxt = len_m1;
            end else begin
              cnt_nxt   = tgt_idx + AW'(1);
              state_nxt = S_DN;
            end
          end
        end
      end
      S_UP: begin
        mem_rd_en = 1'b1;
        mem_wr_en = pend_r;
        pend_nxt  = 1'b1;
        wptr_nxt  = cnt_r + AW'(1);
        if (cnt_r == idx_r) state_nxt = S_UP_LAST;
        else cnt_nxt = cnt_r - AW'(1);
      end
      S_UP_LAST: begin
        mem_wr_en = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = val_r;
        len_nxt     = len_r + LW'(1);
        state_nxt   = S_RESULT;
      end
      S_DN: begin
        mem_rd_en = 1'b1;
        mem_wr_en = pend_r;
        pend_nxt  = 1'b1;
        wptr_nxt  = cnt_r - AW'(1);
        if (is_last) state_nxt = S_DN_LAST;
        else cnt_nxt = cnt_r + AW'(1);
      end
      S_DN_LAST: begin
        mem_wr_en = 1'b1;
        pend_nxt  = 1'b0;
        len_nxt   = len_m1;
        state_nxt = S_RESULT;
      end
      S_DISP_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        res_valid        = 1'b1;
        res_data.status  = ST_OK;
        res_data.element = mem_rd_data;
        res_data.last    = is_last;
        if (res_ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + AW'(1);
            state_nxt = S_DISP_RD;
          end
        end
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
    end
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    wptr_r   <= wptr_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/positional_list_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of signed 32-bit values
// The list is held packed in a single-port-read, single-port-write memory,
// front at entry 0. A request is taken only while the block is idle. An
// error result or a delete of the last entry goes straight to the result;
// a write at the end of the list (create, append, or a position insert
// just past the last entry) writes the new entry and then gives the result.
// An insert shifts the entries from the end down to its index up by one
// before writing the new entry, and a delete shifts the entries above its
// index down by one. One entry is moved per cycle through the memory's
// read port. Display reads each element and then offers it, and reads the
// next one only once it has been taken. Each result passes through an
// output register, so the block can start the next request while the last
// result waits to be taken.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic          res_valid;
  logic          res_ready;
  res_t          res_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;
  logic          out_valid_r;
  res_t          out_data_r;

  ple_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ple_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a previous one is in progress");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last)
    else $error("error result not marked last");

  a_error_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.element == '0))
    else $error("error result carries an element");

endmodule
`default_nettype wire
